>>> design/accm_pkg.sv
// ----------------------------------------------------------------------------
// accm_pkg
// Types and constants shared by the accumulator machine: transaction
// payloads, opcodes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package accm_pkg;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 7;
  localparam int KIND_W   = 7;
  localparam int STATUS_W = 3;

  // instruction word = opcode * INSTR_SCALE + address
  localparam logic [DATA_W-1:0] INSTR_SCALE = 32'd100;

  localparam logic [KIND_W-1:0] OP_WRITE = 7'd10;
  localparam logic [KIND_W-1:0] OP_READ  = 7'd11;
  localparam logic [KIND_W-1:0] OP_LOAD  = 7'd20;
  localparam logic [KIND_W-1:0] OP_STORE = 7'd21;
  localparam logic [KIND_W-1:0] OP_ADD   = 7'd30;
  localparam logic [KIND_W-1:0] OP_SUB   = 7'd31;
  localparam logic [KIND_W-1:0] OP_DIV   = 7'd32;
  localparam logic [KIND_W-1:0] OP_MUL   = 7'd33;
  localparam logic [KIND_W-1:0] OP_HALT  = 7'd99;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [ADDR_W-1:0]        operand_address;
    logic signed [DATA_W-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_value;
    logic signed [DATA_W-1:0] read_value;
    logic [ADDR_W-1:0]        read_address;
    logic [STATUS_W-1:0]      status;
  } result_t;

  // datapath action in the execute step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_STORE,
    ACT_READ,
    ACT_LOAD,
    ACT_ADD,
    ACT_SUB,
    ACT_MUL,
    ACT_DIV
  } act_t;

  typedef struct packed {
    logic                capture;
    logic                clear_step;
    logic                record;
    logic                fetch;
    act_t                act;
    logic                mul_commit;
    logic                div_commit;
    logic                set_stopped;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                publish;
  } cmd_t;

  typedef struct packed {
    logic              clear_done;
    logic              stopped;
    logic              full;
    logic [KIND_W-1:0] kind;
    logic              div_zero;
    logic              div_done;
    logic              out_free;
  } stat_t;

endpackage

>>> design/accm_div.sv
// ----------------------------------------------------------------------------
// accm_div
// Bit-serial signed divider, one quotient bit per cycle, truncating
// toward zero. The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module accm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [accm_pkg::DATA_W-1:0]    dividend,
  input  logic [accm_pkg::DATA_W-1:0]    divisor,
  output logic                           done,
  output logic [accm_pkg::DATA_W-1:0]    quotient
);
  import accm_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem, quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      // restoring step: borrow out of the trial subtract means keep shifted
      if (diff[DATA_W]) begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end else begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end
    end
  end

endmodule

>>> design/accm_dpath.sv
// ----------------------------------------------------------------------------
// accm_dpath
// Datapath: word memory, accumulator, program line counter, read
// registers, multiplier, divider and the result register.
// ----------------------------------------------------------------------------
module accm_dpath #(
  parameter int MEM_WORDS = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  accm_pkg::item_t   item,
  input  logic              result_stall,
  output logic              result_valid,
  output accm_pkg::result_t result,
  input  accm_pkg::cmd_t    cmd,
  output accm_pkg::stat_t   stat
);
  import accm_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int CW = $clog2(MEM_WORDS + 1);
  localparam int WW = (CW > ADDR_W) ? CW : ADDR_W;

  logic [DATA_W-1:0] mem [MEM_WORDS];

  item_t               cur;
  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   prod;
  logic [DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]   last_rd_val;
  logic [ADDR_W-1:0]   last_rd_addr;
  logic [CW-1:0]       line;
  logic [CW-1:0]       clr_idx;
  logic                stopped;
  logic [STATUS_W-1:0] status;

  logic [WW-1:0]     addr_w;
  logic [AW-1:0]     op_idx;
  logic              addr_ok;
  logic [DATA_W-1:0] operand;
  logic [DATA_W-1:0] instr_word;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] quotient;

  assign addr_w     = WW'(cur.operand_address);
  assign op_idx     = addr_w[AW-1:0];
  assign addr_ok    = addr_w < WW'(MEM_WORDS);
  // out-of-range addresses read as zero
  assign operand    = addr_ok ? rdata : '0;
  assign instr_word = DATA_W'(cur.kind) * INSTR_SCALE + DATA_W'(cur.operand_address);
  assign div_start  = (cmd.act == ACT_DIV);

  always_comb begin
    we = 1'b0;
    wa = op_idx;
    wd = cur.write_value;
    if (cmd.clear_step) begin
      we = 1'b1;
      wa = clr_idx[AW-1:0];
      wd = '0;
    end else if (cmd.record) begin
      we = 1'b1;
      wa = line[AW-1:0];
      wd = instr_word;
    end else if (cmd.act == ACT_WRITE) begin
      we = addr_ok;
    end else if (cmd.act == ACT_STORE) begin
      we = addr_ok;
      wd = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.fetch) begin
      rdata <= mem[op_idx];
    end
  end

  accm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (operand),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
    if (cmd.act == ACT_MUL) begin
      prod <= acc * operand;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      last_rd_val  <= '0;
      last_rd_addr <= '0;
      line         <= '0;
      clr_idx      <= '0;
      stopped      <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + CW'(1);
      end
      if (cmd.record) begin
        line <= line + CW'(1);
      end
      if (cmd.set_stopped) begin
        stopped <= 1'b1;
      end
      case (cmd.act)
        ACT_READ: begin
          last_rd_val  <= operand;
          last_rd_addr <= cur.operand_address;
        end
        ACT_LOAD: acc <= operand;
        ACT_ADD:  acc <= acc + operand;
        ACT_SUB:  acc <= acc - operand;
        default: ;
      endcase
      if (cmd.mul_commit) begin
        acc <= prod;
      end else if (cmd.div_commit) begin
        acc <= quotient;
      end
    end
  end

  // result register: holds until taken, reloads in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.acc_value    <= acc;
      result.read_value   <= last_rd_val;
      result.read_address <= last_rd_addr;
      result.status       <= status;
    end
  end

  assign stat.clear_done = (clr_idx == CW'(MEM_WORDS - 1));
  assign stat.stopped    = stopped;
  assign stat.full       = (line == CW'(MEM_WORDS));
  assign stat.kind       = cur.kind;
  assign stat.div_zero   = (operand == '0);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !result_valid || !result_stall;

endmodule

>>> design/accm_ctrl.sv
// ----------------------------------------------------------------------------
// accm_ctrl
// Controller: sequences memory clear, instruction checks, recording,
// operand fetch, execution and result hand-off.
// ----------------------------------------------------------------------------
module accm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  accm_pkg::stat_t stat,
  output accm_pkg::cmd_t  cmd
);
  import accm_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_RECORD = 9'b000001000,
    S_FETCH  = 9'b000010000,
    S_EXEC   = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.act    = ACT_NONE;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.set_status = 1'b1;
        state_next     = S_OUT;
        if (stat.stopped) begin
          cmd.status = ST_STOPPED;
        end else if (stat.kind == OP_HALT) begin
          cmd.set_stopped = 1'b1;
          cmd.status      = ST_STOPPED;
        end else if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.status = ST_OK;
          state_next = S_RECORD;
        end
      end
      S_RECORD: begin
        cmd.record = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        // read issued after the record write, so it sees the new word
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
        case (stat.kind)
          OP_WRITE: cmd.act = ACT_WRITE;
          OP_READ:  cmd.act = ACT_READ;
          OP_LOAD:  cmd.act = ACT_LOAD;
          OP_STORE: cmd.act = ACT_STORE;
          OP_ADD:   cmd.act = ACT_ADD;
          OP_SUB:   cmd.act = ACT_SUB;
          OP_MUL: begin
            cmd.act    = ACT_MUL;
            state_next = S_MUL;
          end
          OP_DIV: begin
            if (stat.div_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DIVZERO;
            end else begin
              cmd.act    = ACT_DIV;
              state_next = S_DIV;
            end
          end
          default: begin
            cmd.set_stopped = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status      = ST_INVALID;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul_commit = 1'b1;
        state_next     = S_OUT;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_commit = 1'b1;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/accumulator_machine_step.sv
// ----------------------------------------------------------------------------
// accumulator_machine_step
// Accumulator machine that records and executes instructions on entry.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. After reset the block clears the
// word memory, one word per cycle, with item stall high. Each accepted
// item then passes check, record, operand fetch from the registered memory
// port, execute and result load for write, read, load, store, add and sub;
// multiply adds a commit after execute (registered product), and divide
// waits after execute on the 32-step bit-serial divider. A refused item
// or a halt goes from check straight to result load. A finished result
// sits in the output register, so a stall on the result side only holds
// the machine at the result load of the following item.
module accumulator_machine_step #(
  parameter int MEM_WORDS = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  accm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output accm_pkg::result_t result
);
  import accm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  accm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  accm_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for accumulator_machine_step: a shadow copy of the
// machine predicts every result from the accepted instruction stream, with
// bursty input traffic and a result side that stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import accm_pkg::*;

  localparam int MEM_WORDS   = 100;
  localparam int DIRECTED_N  = 25;
  localparam int ITEM_TOTAL  = 1850;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;
  localparam int REPORT_CAP  = 100;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct {
    item_t payload;
    bit    drain_first;  // hold off until every outstanding result is back
  } instr_entry_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  instr_entry_t instr_q[$];
  result_t      state_after_q[$];
  int           mismatch_count = 0;
  int           accepted_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  stall_style_t stall_style = STALL_NONE;
  int           stall_left = 0;

  // shadow machine
  logic [DATA_W-1:0] word_mem [MEM_WORDS];
  logic [DATA_W-1:0] acc_word;
  logic [DATA_W-1:0] last_rd_word;
  logic [ADDR_W-1:0] last_rd_addr;
  int                program_line;
  bit                machine_stopped;

  always #5 clk = ~clk;

  accumulator_machine_step #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  function automatic logic [DATA_W-1:0] word_at(logic [ADDR_W-1:0] a);
    return (a < MEM_WORDS) ? word_mem[a] : '0;
  endfunction

  function automatic void put_word(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] v);
    if (a < MEM_WORDS) word_mem[a] = v;
  endfunction

  function automatic logic [DATA_W-1:0] quotient_trunc(logic [DATA_W-1:0] n,
                                                       logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] q;
    mag_n = n[DATA_W-1] ? -n : n;
    mag_d = d[DATA_W-1] ? -d : d;
    q = mag_n / mag_d;
    return (n[DATA_W-1] != d[DATA_W-1]) ? -q : q;
  endfunction

  // Record, then execute; queues the machine state seen after the instruction.
  task automatic execute_instruction(input item_t it);
    logic [DATA_W-1:0]   operand;
    logic [STATUS_W-1:0] st;
    result_t             r;
    st = ST_OK;
    if (machine_stopped) begin
      st = ST_STOPPED;
    end else if (it.kind == OP_HALT) begin
      machine_stopped = 1'b1;
      st = ST_STOPPED;
    end else if (program_line >= MEM_WORDS) begin
      st = ST_FULL;
    end else begin
      word_mem[program_line] = DATA_W'(it.kind) * INSTR_SCALE + DATA_W'(it.operand_address);
      program_line++;
      operand = word_at(it.operand_address);  // sees the word just recorded
      case (it.kind)
        OP_WRITE: put_word(it.operand_address, it.write_value);
        OP_READ: begin
          last_rd_word = operand;
          last_rd_addr = it.operand_address;
        end
        OP_LOAD:  acc_word = operand;
        OP_STORE: put_word(it.operand_address, acc_word);
        OP_ADD:   acc_word = acc_word + operand;
        OP_SUB:   acc_word = acc_word - operand;
        OP_DIV: begin
          if (operand == '0) st = ST_DIVZERO;
          else acc_word = quotient_trunc(acc_word, operand);
        end
        OP_MUL:   acc_word = acc_word * operand;
        default: begin
          machine_stopped = 1'b1;
          st = ST_INVALID;
        end
      endcase
    end
    r.acc_value    = acc_word;
    r.read_value   = last_rd_word;
    r.read_address = last_rd_addr;
    r.status       = st;
    state_after_q.push_back(r);
  endtask

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      if (mismatch_count < REPORT_CAP)
        $error("%s mismatch: expected %0d (0x%08h) actual %0d (0x%08h)",
               name, $signed(want), want, $signed(got), got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_instr(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] value, input bit drain);
    instr_entry_t e;
    e.payload.kind            = kind;
    e.payload.operand_address = addr;
    e.payload.write_value     = value;
    e.drain_first             = drain;
    instr_q.push_back(e);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '1;
          3: return '0;
          default: return 32'd1;
        endcase
      end
      1, 2: return DATA_W'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  // mostly the data area, some out of range, some program lines
  function automatic logic [ADDR_W-1:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return ADDR_W'($urandom_range(50, 99));
    if (r < 80) return ADDR_W'($urandom_range(100, 127));
    return ADDR_W'($urandom_range(0, 49));
  endfunction

  function automatic logic [KIND_W-1:0] pick_valid_op();
    case ($urandom_range(0, 7))
      0: return OP_WRITE;
      1: return OP_READ;
      2: return OP_LOAD;
      3: return OP_STORE;
      4: return OP_ADD;
      5: return OP_SUB;
      6: return OP_DIV;
      default: return OP_MUL;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_invalid_op();
    logic [KIND_W-1:0] k;
    do
      k = KIND_W'($urandom_range(0, 127));
    while (k inside {OP_WRITE, OP_READ, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                     OP_DIV, OP_MUL, OP_HALT});
    return k;
  endfunction

  // driver
  always @(posedge clk) begin
    bit           can_load;
    instr_entry_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      can_load = !item_valid || !item_stall;
      if (item_valid && !item_stall) begin
        execute_instruction(item);
        accepted_count++;
      end
      if (can_load) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (instr_q.size() == 0 ||
                     (instr_q[0].drain_first && state_after_q.size() != 0)) begin
          item_valid <= 1'b0;
        end else begin
          nxt = instr_q.pop_front();
          item <= nxt.payload;
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 5))
              0, 1: gap_left = 0;
              2, 3, 4: gap_left = $urandom_range(1, 5);
              default: gap_left = $urandom_range(10, 25);
            endcase
          end
        end
      end
    end
  end

  // monitor and result-side stall pattern
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (state_after_q.size() == 0) begin
          if (mismatch_count < REPORT_CAP)
            $error("unexpected transaction: acc_value %0d status %0d",
                   result.acc_value, result.status);
          mismatch_count++;
        end else begin
          want = state_after_q.pop_front();
          check_field("acc_value", want.acc_value, result.acc_value);
          check_field("read_value", want.read_value, result.read_value);
          check_field("read_address", DATA_W'(want.read_address),
                      DATA_W'(result.read_address));
          check_field("status", DATA_W'(want.status), DATA_W'(result.status));
        end
      end
      if (stall_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        stall_left = $urandom_range(50, 300);
      end else begin
        stall_left--;
      end
      case (stall_style)
        STALL_NONE:  result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 2) == 0);
        STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default:     result_stall <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    bit                stop_on_invalid;
    int                halt_at;
    logic [KIND_W-1:0] k;

    for (int i = 0; i < MEM_WORDS; i++) word_mem[i] = '0;
    acc_word        = '0;
    last_rd_word    = '0;
    last_rd_addr    = '0;
    program_line    = 0;
    machine_stopped = 1'b0;

    // The machine stops for good once, either on halt or on a bad opcode.
    stop_on_invalid = ($urandom_range(0, 2) == 0);
    halt_at = $urandom_range(1000, 1650);

    // directed: extremes, wrap cases, divide corners, range and overlap
    queue_instr(OP_WRITE, 7'd90, WORD_MAX, 1'b0);
    queue_instr(OP_WRITE, 7'd91, WORD_MIN, 1'b0);
    queue_instr(OP_WRITE, 7'd92, '1, 1'b0);
    queue_instr(OP_LOAD, 7'd91, '0, 1'b0);
    queue_instr(OP_DIV, 7'd92, '0, 1'b0);        // most negative / -1 wraps
    queue_instr(OP_ADD, 7'd90, '0, 1'b0);
    queue_instr(OP_MUL, 7'd90, '0, 1'b0);
    queue_instr(OP_SUB, 7'd91, '0, 1'b0);
    queue_instr(OP_WRITE, 7'd93, -32'sd7, 1'b0);
    queue_instr(OP_LOAD, 7'd93, '0, 1'b0);
    queue_instr(OP_WRITE, 7'd94, 32'd2, 1'b0);
    queue_instr(OP_DIV, 7'd94, '0, 1'b0);        // truncates toward zero
    queue_instr(OP_DIV, 7'd95, '0, 1'b0);        // zero divisor
    queue_instr(OP_DIV, 7'd127, '0, 1'b0);       // out of range reads zero
    queue_instr(OP_WRITE, 7'd120, 32'd5, 1'b0);  // dropped
    queue_instr(OP_READ, 7'd120, '0, 1'b0);
    queue_instr(OP_READ, 7'd90, '0, 1'b0);
    queue_instr(OP_STORE, 7'd96, '0, 1'b0);
    queue_instr(OP_WRITE, 7'd18, 32'h5A5A_5A5A, 1'b0);  // overwrites its own record
    queue_instr(OP_READ, 7'd18, '0, 1'b0);
    queue_instr(OP_READ, 7'd20, '0, 1'b0);       // reads its own record
    queue_instr(OP_WRITE, 7'd22, 32'd123, 1'b0); // next record lands on it
    queue_instr(OP_LOAD, 7'd0, '0, 1'b0);
    queue_instr(OP_READ, 7'd22, '0, 1'b0);
    queue_instr(OP_MUL, 7'd127, '0, 1'b0);

    // fill the rest of the program store: valid ops, but the last may be invalid
    for (int line = DIRECTED_N; line < MEM_WORDS; line++) begin
      if (stop_on_invalid && line == MEM_WORDS - 1)
        k = pick_invalid_op();
      else
        k = pick_valid_op();
      queue_instr(k, pick_address(), pick_value(), line == DIRECTED_N);
    end

    // store full or machine stopped: everything is refused from here
    for (int n = 0; n < ITEM_TOTAL - MEM_WORDS; n++) begin
      if (!stop_on_invalid && n == halt_at) begin
        queue_instr(OP_HALT, ADDR_W'($urandom_range(0, 127)), $urandom(), 1'b1);
      end else begin
        do
          k = KIND_W'($urandom_range(0, 127));
        while (!stop_on_invalid && n < halt_at && k == OP_HALT);
        queue_instr(k, ADDR_W'($urandom_range(0, 127)), pick_value(),
                    n == 0 || $urandom_range(0, 199) == 0);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < ITEM_TOTAL) @(posedge clk);
    while (state_after_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && state_after_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
